// ===== rtl/sebfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sebfr_pkg
// shared types and constants of the stx/etx/bcc frame receiver
// ----------------------------------------------------------------------------
package sebfr_pkg;

	// framing characters
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] CH_F   = 8'h46;

	// default frame memory depth
	localparam int FRAME_DEPTH_DEF = 64;

	// default timeout in ticks
	localparam logic [15:0] TIMEOUT_DEF = 16'd100;

	// input word kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BCC_ERR  = 2'd1;
	localparam logic [1:0] ST_NOT_MINE = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	// configuration register indexes
	localparam logic REG_READER_ADDRESS = 1'b0;
	localparam logic REG_FRAME_TIMEOUT  = 1'b1;

	// receiver phase, one-hot
	typedef enum logic [3:0] {
		PH_HUNT  = 4'b0001,
		PH_BODY  = 4'b0010,
		PH_CHECK = 4'b0100,
		PH_SEND  = 4'b1000
	} phase_t;

endpackage

// ===== rtl/sebfr_ram.sv =====
// ----------------------------------------------------------------------------
// sebfr_ram
// generic single-clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module sebfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// read data holds while no read is issued
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/stx_etx_bcc_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// stx_etx_bcc_frame_receiver_top
// results: a status result enters the output register as its check byte is
//   taken; a payload run passes the phase, ram read and output registers, then
//   one word and one memory read a cycle while out_stall is low
// throughput: one input word a cycle unless in_stall; input stalls during a payload run
// reset: asynchronous, active low; frame memory contents are not cleared
// ----------------------------------------------------------------------------
module stx_etx_bcc_frame_receiver_top #(
	parameter int FRAME_DEPTH = sebfr_pkg::FRAME_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  frame_status,
	output logic [7:0]  payload_byte,
	output logic        has_payload,
	output logic        last
);

	import sebfr_pkg::*;

	// count must reach the depth itself, address only depth-1
	localparam int CNT_W = $clog2(FRAME_DEPTH + 1);
	localparam int AW    = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FRAME_DEPTH);
	localparam logic [CNT_W-1:0] ADDR_LEN = CNT_W'(2);

	// configuration registers
	logic [6:0]  reader_addr_q;
	logic [15:0] timeout_q;

	// frame state
	phase_t           phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       xor_q;
	logic [15:0]      elapsed_q;
	logic             ovf_q;
	logic [7:0]       addr_hi_q;
	logic [7:0]       addr_lo_q;

	// payload read-out
	logic [CNT_W-1:0] rd_ptr_q;
	logic             pend_q;       // ram read data holds a payload word
	logic             pend_last_q;

	// output register
	logic       out_valid_q;
	logic [1:0] out_status_q;
	logic [7:0] out_byte_q;
	logic       out_has_q;
	logic       out_last_q;

	// handshake and decode
	logic       in_acc;
	logic       out_free;
	logic       byte_acc;
	logic       tick_acc;
	logic       timed_out;
	phase_t     eff_phase;

	// check byte evaluation
	logic       bcc_ok;
	logic       addr_ok;
	logic       hi_dec;
	logic       lo_dec;
	logic [6:0] addr_val;
	logic       start_send;
	logic       status_load;
	logic [1:0] status_code;

	// frame memory access
	logic          ram_wr_en;
	logic          ram_rd_en;
	logic [7:0]    ram_rd_data;
	logic          load_out;

	assign out_free = !out_valid_q || !out_stall;

	// no input while a payload run streams out; a check byte needs a free
	// output register
	assign in_stall = (phase_q == PH_SEND) || ((phase_q == PH_CHECK) && !out_free);

	assign in_acc   = in_valid && !in_stall;
	assign byte_acc = in_acc && (kind == KIND_BYTE);
	assign tick_acc = in_acc && (kind == KIND_TICK);

	// an expired frame is dropped silently and the byte is taken as hunting
	assign timed_out = (phase_q != PH_HUNT) && (elapsed_q >= timeout_q);
	assign eff_phase = timed_out ? PH_HUNT : phase_q;

	// address: two ascii digits or broadcast "FF"
	assign hi_dec   = (addr_hi_q >= 8'h30) && (addr_hi_q <= 8'h39);
	assign lo_dec   = (addr_lo_q >= 8'h30) && (addr_lo_q <= 8'h39);
	assign addr_val = 7'({addr_hi_q[3:0], 3'b000}) + 7'({addr_hi_q[3:0], 1'b0})
		+ 7'(addr_lo_q[3:0]);
	assign addr_ok  = (cnt_q >= ADDR_LEN) &&
		(((addr_hi_q == CH_F) && (addr_lo_q == CH_F)) ||
		 (hi_dec && lo_dec && (addr_val == reader_addr_q)));

	assign bcc_ok = ((xor_q ^ CH_ETX) == rx_byte);

	// status priority: overflow, check byte, address, empty payload
	always_comb begin
		priority if (ovf_q) begin
			status_code = ST_OVERFLOW;
		end else if (!bcc_ok) begin
			status_code = ST_BCC_ERR;
		end else if (!addr_ok) begin
			status_code = ST_NOT_MINE;
		end else begin
			status_code = ST_OK;
		end
	end

	assign start_send  = byte_acc && (eff_phase == PH_CHECK) && !ovf_q && bcc_ok &&
		addr_ok && (cnt_q > ADDR_LEN);
	assign status_load = byte_acc && (eff_phase == PH_CHECK) && !start_send;

	// body bytes go to the frame memory until it is full
	assign ram_wr_en = byte_acc && (eff_phase == PH_BODY) && (rx_byte != CH_ETX) &&
		(cnt_q < DEPTH_C);

	// read-out: a pending word moves to the output register when it is free,
	// the next read is issued once the pending slot empties in the same cycle
	assign load_out  = pend_q && out_free;
	assign ram_rd_en = (phase_q == PH_SEND) && (rd_ptr_q < cnt_q) && (!pend_q || load_out);

	sebfr_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_DEPTH)
	) u_frame_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(cnt_q[AW-1:0]),
		.wr_data(rx_byte),
		.rd_en  (ram_rd_en),
		.rd_addr(rd_ptr_q[AW-1:0]),
		.rd_data(ram_rd_data)
	);

	// configuration registers, to be written only while idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reader_addr_q <= '0;
			timeout_q     <= TIMEOUT_DEF;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_READER_ADDRESS: reader_addr_q <= cfg_data[6:0];
				REG_FRAME_TIMEOUT:  timeout_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			cnt_q       <= '0;
			xor_q       <= '0;
			elapsed_q   <= '0;
			ovf_q       <= 1'b0;
			rd_ptr_q    <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			// millisecond ticks count only inside an open frame, saturating
			if (tick_acc && (phase_q != PH_HUNT) && (elapsed_q != '1)) begin
				elapsed_q <= elapsed_q + 16'd1;
			end

			if (byte_acc) begin
				unique case (eff_phase)
					PH_HUNT: begin
						if (rx_byte == CH_STX) begin
							phase_q   <= PH_BODY;
							cnt_q     <= '0;
							xor_q     <= '0;
							elapsed_q <= '0;
							ovf_q     <= 1'b0;
						end else begin
							phase_q <= PH_HUNT;
						end
					end
					PH_BODY: begin
						if (rx_byte == CH_ETX) begin
							phase_q <= PH_CHECK;
						end else if (cnt_q < DEPTH_C) begin
							cnt_q <= cnt_q + CNT_W'(1);
							xor_q <= xor_q ^ rx_byte;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					PH_CHECK: begin
						if (start_send) begin
							phase_q  <= PH_SEND;
							rd_ptr_q <= ADDR_LEN;
						end else begin
							phase_q <= PH_HUNT;
						end
					end
					default: phase_q <= phase_q;
				endcase
			end

			// payload read-out
			if (ram_rd_en) begin
				rd_ptr_q    <= rd_ptr_q + CNT_W'(1);
				pend_q      <= 1'b1;
				pend_last_q <= ((rd_ptr_q + CNT_W'(1)) == cnt_q);
			end else if (load_out) begin
				pend_q <= 1'b0;
			end
			if (load_out && pend_last_q) begin
				phase_q <= PH_HUNT;
			end
		end
	end

	// the two address bytes are kept beside the memory
	always_ff @(posedge clk) begin
		if (ram_wr_en && (cnt_q == CNT_W'(0))) begin
			addr_hi_q <= rx_byte;
		end
		if (ram_wr_en && (cnt_q == CNT_W'(1))) begin
			addr_lo_q <= rx_byte;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (status_load || load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (status_load) begin
			out_status_q <= status_code;
			out_byte_q   <= '0;
			out_has_q    <= 1'b0;
			out_last_q   <= 1'b1;
		end else if (load_out) begin
			out_status_q <= ST_OK;
			out_byte_q   <= ram_rd_data;
			out_has_q    <= 1'b1;
			out_last_q   <= pend_last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_status = out_status_q;
	assign payload_byte = out_byte_q;
	assign has_payload  = out_has_q;
	assign last         = out_last_q;

`ifndef SYNTHESIS
	// a pending read word exists only during a payload run
	a_pend_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (phase_q == PH_SEND))
		else $error("read word pending outside payload run");

	// fill count never passes the memory depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("fill count beyond frame depth");

	// read pointer stays inside the stored frame
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SEND) |-> (rd_ptr_q <= cnt_q))
		else $error("read pointer beyond stored bytes");

	// handing over the last payload word closes the frame
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && pend_last_q) |=> (phase_q == PH_HUNT) && !pend_q)
		else $error("payload run did not end after last word");
`endif

endmodule

// ===== test/stx_etx_bcc_frame_receiver_checker.sv =====
// ----------------------------------------------------------------------------
// stx_etx_bcc_frame_receiver_checker
// watches both channels of the frame receiver, keeps its own model of the
// framing state and compares every result word field by field, in order
// ----------------------------------------------------------------------------
module stx_etx_bcc_frame_receiver_checker #(
	parameter int FRAME_DEPTH = sebfr_pkg::FRAME_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              kind,
	input  logic [7:0]        rx_byte,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        frame_status,
	input  logic [7:0]        payload_byte,
	input  logic              has_payload,
	input  logic              last,
	output int unsigned       mismatches,
	output int unsigned       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import sebfr_pkg::*;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] data;
		logic       has_data;
		logic       final_word;
	} frame_result_t;

	frame_result_t expected_results[$];

	// model of the receiver
	phase_t      rx_phase;
	logic [7:0]  frame_bytes [FRAME_DEPTH];
	int unsigned byte_count;
	logic [7:0]  check_acc;
	logic [15:0] tick_count;
	logic        overrun;
	logic [6:0]  station_addr;
	logic [15:0] timeout_limit;

	task automatic report_mismatch(input string field, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t ns: %s mismatch, got %0h expected %0h", $time, field, got, want);
		mismatches++;
	endtask

	task automatic queue_result(input logic [1:0] status, input logic [7:0] data,
			input logic has_data, input logic final_word);
		frame_result_t r;
		r.status     = status;
		r.data       = data;
		r.has_data   = has_data;
		r.final_word = final_word;
		expected_results.push_back(r);
	endtask

	// two ascii decimal digits equal to the station, or "FF" for everyone
	function automatic bit station_addressed();
		int hi;
		int lo;
		if (byte_count < 2) return 1'b0;
		hi = int'(frame_bytes[0]);
		lo = int'(frame_bytes[1]);
		if (hi == int'(CH_F) && lo == int'(CH_F)) return 1'b1;
		if (hi < "0" || hi > "9" || lo < "0" || lo > "9") return 1'b0;
		return ((hi - "0") * 10 + (lo - "0")) == int'(station_addr);
	endfunction

	task automatic predict_frame_word(input logic k, input logic [7:0] b);
		if (k == KIND_TICK) begin
			if (rx_phase != PH_HUNT && tick_count != 16'hFFFF) tick_count++;
			return;
		end
		// an expired frame is dropped silently, the byte is then seen while hunting
		if (rx_phase != PH_HUNT && tick_count >= timeout_limit) rx_phase = PH_HUNT;
		case (rx_phase)
			PH_BODY: begin
				if (b == CH_ETX) begin
					rx_phase = PH_CHECK;
				end else if (byte_count < FRAME_DEPTH) begin
					frame_bytes[byte_count] = b;
					byte_count++;
					check_acc ^= b;
				end else begin
					overrun = 1'b1;
				end
			end
			PH_CHECK: begin
				rx_phase = PH_HUNT;
				if (overrun) begin
					queue_result(ST_OVERFLOW, 8'h00, 1'b0, 1'b1);
				end else if ((check_acc ^ CH_ETX) != b) begin
					queue_result(ST_BCC_ERR, 8'h00, 1'b0, 1'b1);
				end else if (!station_addressed()) begin
					queue_result(ST_NOT_MINE, 8'h00, 1'b0, 1'b1);
				end else if (byte_count <= 2) begin
					queue_result(ST_OK, 8'h00, 1'b0, 1'b1);
				end else begin
					for (int i = 2; i < byte_count; i++)
						queue_result(ST_OK, frame_bytes[i], 1'b1, i == byte_count - 1);
				end
			end
			default: begin
				rx_phase = PH_HUNT;
				if (b == CH_STX) begin
					rx_phase   = PH_BODY;
					byte_count = 0;
					check_acc  = 8'h00;
					tick_count = 16'h0000;
					overrun    = 1'b0;
				end
			end
		endcase
	endtask

	task automatic check_result_word();
		frame_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result word with none expected", payload_byte, 8'h00);
			return;
		end
		want = expected_results.pop_front();
		if (frame_status !== want.status)
			report_mismatch("frame_status", 8'(frame_status), 8'(want.status));
		if (payload_byte !== want.data)
			report_mismatch("payload_byte", payload_byte, want.data);
		if (has_payload !== want.has_data)
			report_mismatch("has_payload", 8'(has_payload), 8'(want.has_data));
		if (last !== want.final_word)
			report_mismatch("last", 8'(last), 8'(want.final_word));
	endtask

	// results seen at an edge stem from earlier words, so compare before predicting
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase      = PH_HUNT;
			byte_count    = 0;
			check_acc     = 8'h00;
			tick_count    = 16'h0000;
			overrun       = 1'b0;
			station_addr  = 7'd0;
			timeout_limit = TIMEOUT_DEF;
			mismatches    = 0;
			expected_results.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_READER_ADDRESS: station_addr  = cfg_data[6:0];
					REG_FRAME_TIMEOUT:  timeout_limit = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) check_result_word();
			if (in_valid && !in_stall) predict_frame_word(kind, rx_byte);
		end
		outstanding = expected_results.size();
	end

endmodule

// ===== test/stx_etx_bcc_frame_receiver_top_test.sv =====
// ----------------------------------------------------------------------------
// stx_etx_bcc_frame_receiver_top_test
// drives byte and tick words into the frame receiver: hand-picked frames for
// every ending of a frame, then random frames, broken frames and line noise
// under several station and timeout settings, with random gaps and stalls
// ----------------------------------------------------------------------------
module stx_etx_bcc_frame_receiver_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sebfr_pkg::*;

	typedef logic [7:0] octet_t;

	// how the two address bytes of a generated frame are chosen
	localparam int ADDR_OWN       = 0;
	localparam int ADDR_BROADCAST = 1;
	localparam int ADDR_DECIMAL   = 2;
	localparam int ADDR_ANY       = 3;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  frame_status;
	logic [7:0]  payload_byte;
	logic        has_payload;
	logic        last;

	int unsigned mismatches;
	int unsigned outstanding;

	// stimulus side bookkeeping
	bit          calm;          // no gaps and no stalls while set
	logic [6:0]  station_now;
	logic [15:0] timeout_now;
	octet_t      frame_body[$]; // stored bytes of the next frame, address first
	int unsigned words_sent;

	stx_etx_bcc_frame_receiver_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_status (frame_status),
		.payload_byte (payload_byte),
		.has_payload  (has_payload),
		.last         (last)
	);

	stx_etx_bcc_frame_receiver_checker #(
		.FRAME_DEPTH (FRAME_DEPTH_DEF)
	) frame_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_status (frame_status),
		.payload_byte (payload_byte),
		.has_payload  (has_payload),
		.last         (last),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop, far beyond the slowest good run
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// result side stalls about one cycle in ten
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= !calm && ($urandom_range(99) < 10);
		end
	end

	// one word through the input channel, sometimes after a short gap
	task automatic put_word(input logic k, input octet_t b);
		if (!calm && $urandom_range(99) < 4) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// hold the input until every expected result is out, then let the block settle
	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (8) @(posedge clk);
	endtask

	// both registers, back to back, only while the block is quiet
	task automatic set_config(input logic [6:0] addr, input logic [15:0] ticks);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_READER_ADDRESS;
		cfg_data  <= {9'd0, addr};
		@(posedge clk);
		cfg_index <= REG_FRAME_TIMEOUT;
		cfg_data  <= ticks;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		station_now = addr;
		timeout_now = ticks;
	endtask

	// any byte but ETX, so that the body does not end early
	function automatic octet_t body_byte();
		octet_t b;
		do b = octet_t'($urandom); while (b == CH_ETX);
		return b;
	endfunction

	// noise leans on the framing characters
	function automatic octet_t noise_byte();
		int r;
		r = $urandom_range(99);
		if (r < 20) return CH_STX;
		if (r < 40) return CH_ETX;
		return octet_t'($urandom);
	endfunction

	task automatic push_address(input int mode);
		int n;
		case (mode)
			ADDR_OWN: begin
				// a station above 99 has no decimal form, so any pair will do
				n = (station_now <= 99) ? int'(station_now) : $urandom_range(99);
				frame_body.push_back(octet_t'("0" + n / 10));
				frame_body.push_back(octet_t'("0" + n % 10));
			end
			ADDR_BROADCAST: begin
				frame_body.push_back(CH_F);
				frame_body.push_back(CH_F);
			end
			ADDR_DECIMAL: begin
				frame_body.push_back(octet_t'("0" + $urandom_range(9)));
				frame_body.push_back(octet_t'("0" + $urandom_range(9)));
			end
			default: begin
				frame_body.push_back(octet_t'($urandom));
				frame_body.push_back(octet_t'($urandom));
			end
		endcase
	endtask

	// STX, body with optional ticks, ticks before ETX, ETX, check byte
	task automatic send_frame(input bit spoil, input int tick_pct, input int trailing_ticks);
		octet_t check;
		check = CH_ETX;
		put_word(KIND_BYTE, CH_STX);
		foreach (frame_body[i]) begin
			if ($urandom_range(99) < tick_pct) put_word(KIND_TICK, octet_t'($urandom));
			put_word(KIND_BYTE, frame_body[i]);
			check ^= frame_body[i];
		end
		repeat (trailing_ticks) put_word(KIND_TICK, octet_t'($urandom));
		put_word(KIND_BYTE, CH_ETX);
		if (spoil) check ^= 8'h01 << $urandom_range(7);
		put_word(KIND_BYTE, check);
	endtask

	task automatic random_frame(input int tick_pct);
		int  r;
		int  payload_len;
		int  mode;
		int  trailing;
		bit  spoil;
		r = $urandom_range(99);
		if (r < 70)      payload_len = $urandom_range(8);
		else if (r < 85) payload_len = $urandom_range(9, 30);
		else if (r < 95) payload_len = $urandom_range(60, 62);
		else             payload_len = $urandom_range(63, 66);   // runs past the store
		r = $urandom_range(99);
		if (r < 50)      mode = ADDR_OWN;
		else if (r < 70) mode = ADDR_BROADCAST;
		else if (r < 85) mode = ADDR_DECIMAL;
		else             mode = ADDR_ANY;
		frame_body = {};
		if ($urandom_range(99) < 5) begin
			// too short to hold an address
			repeat ($urandom_range(1)) frame_body.push_back(body_byte());
		end else begin
			push_address(mode);
			repeat (payload_len) frame_body.push_back(body_byte());
		end
		spoil = $urandom_range(99) < 15;
		// with a short timeout, land ticks on both sides of the limit
		trailing = (timeout_now <= 40 && $urandom_range(99) < 20) ?
			$urandom_range(timeout_now + 1) : 0;
		send_frame(spoil, tick_pct, trailing);
	endtask

	// a frame that is opened and then runs into ticks or garbage
	task automatic broken_frame();
		put_word(KIND_BYTE, CH_STX);
		repeat ($urandom_range(4)) put_word(KIND_BYTE, body_byte());
		if (timeout_now <= 40)
			repeat (int'(timeout_now) + $urandom_range(2)) put_word(KIND_TICK, octet_t'($urandom));
		repeat ($urandom_range(3)) put_word(KIND_BYTE, noise_byte());
	endtask

	task automatic random_noise();
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(99) < 30) put_word(KIND_TICK, octet_t'($urandom));
			else put_word(KIND_BYTE, noise_byte());
		end
	endtask

	// mostly well-formed frames, the rest broken frames, noise and full drains
	task automatic random_phase(input int n_words, input int tick_pct);
		int unsigned stop_at;
		int          r;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			r = $urandom_range(99);
			if (r < 70)      random_frame(tick_pct);
			else if (r < 85) broken_frame();
			else if (r < 97) random_noise();
			else             wait_quiet();
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_index   <= REG_READER_ADDRESS;
		cfg_data    <= 16'h0000;
		in_valid    <= 1'b0;
		kind        <= KIND_BYTE;
		rx_byte     <= 8'h00;
		calm        = 1'b0;
		station_now = 7'd0;
		timeout_now = TIMEOUT_DEF;
		words_sent  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hand-picked words, reset settings: station 0, timeout 100
		// stray words while hunting give nothing
		put_word(KIND_TICK, 8'hFF);
		put_word(KIND_BYTE, 8'h00);
		put_word(KIND_BYTE, 8'hFF);
		put_word(KIND_BYTE, CH_ETX);
		// payload with extreme bytes and an STX kept as data, ticks under the limit
		frame_body = '{8'h30, 8'h30, 8'h00, 8'hFF, CH_STX};
		send_frame(1'b0, 0, 2);
		// address only: one ok word without payload
		frame_body = '{8'h30, 8'h30};
		send_frame(1'b0, 0, 0);
		// broadcast
		frame_body = '{CH_F, CH_F, 8'hA5};
		send_frame(1'b0, 0, 0);
		// empty body and a one byte body: short address
		frame_body = {};
		send_frame(1'b0, 0, 0);
		frame_body = '{8'h30};
		send_frame(1'b0, 0, 0);
		// another station
		frame_body = '{8'h30, 8'h31, 8'h11};
		send_frame(1'b0, 0, 0);
		// just outside the digit range, and a half broadcast
		frame_body = '{8'h2F, 8'h3A};
		send_frame(1'b0, 0, 0);
		frame_body = '{CH_F, 8'h30};
		send_frame(1'b0, 0, 0);
		// wrong check byte
		frame_body = '{8'h30, 8'h30, 8'h55};
		send_frame(1'b1, 0, 0);
		wait_quiet();

		// top station, shortest timeout: a single tick kills the frame
		set_config(7'd99, 16'd1);
		frame_body = {};
		push_address(ADDR_OWN);
		repeat (62) frame_body.push_back(body_byte());   // fills the store exactly
		send_frame(1'b0, 0, 0);
		random_phase(20, 5);
		wait_quiet();

		// station that never matches, longest timeout
		set_config(7'd127, 16'hFFFF);
		frame_body = {};
		push_address(ADDR_BROADCAST);
		repeat (63) frame_body.push_back(body_byte());   // one past the store
		send_frame(1'b0, 0, 0);
		// a few ticks stay far under the longest limit
		frame_body = '{CH_F, CH_F, 8'h5A};
		send_frame(1'b0, 0, 3);
		calm = 1'b1;
		random_phase(40, 3);
		calm = 1'b0;
		wait_quiet();

		// random station, short random timeout, plenty of ticks inside frames
		set_config(7'($urandom_range(99)), 16'($urandom_range(2, 40)));
		random_phase(30, 10);
		wait_quiet();

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
